@@ design/ogm_pkg.sv @@
`default_nettype none
package ogm_pkg;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_FREE     = 2'd2;
  localparam logic [1:0] ST_NEAR     = 2'd3;

  localparam logic [1:0] CLS_TRAV = 2'd2;

  localparam logic [2:0] REG_ROBOT_X = 3'd0;
  localparam logic [2:0] REG_ROBOT_Y = 3'd1;
  localparam logic [2:0] REG_CELL    = 3'd2;
  localparam logic [2:0] REG_HALF    = 3'd3;
  localparam logic [2:0] REG_WIN_X   = 3'd4;
  localparam logic [2:0] REG_WIN_Y   = 3'd5;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [34:0] num;   // signed numerator
    logic [16:0] den;   // 2*cell_size, positive
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [34:0] quo;   // signed floor quotient
  } div_rsp_t;
endpackage
`default_nettype wire

@@ design/occupancy_grid_marker_core.sv @@
`default_nettype none
// Channel | Dir | tdata (low bit up)                                      | tuser
// in_     | in  | command[1:0] x[33:2] y[65:34] cls[67:66] row[74:68] col[81:75] | -
// out_    | out | cell_row[6:0] cell_col[13:7] cell_state[15:14] written[16] | -
// cfg_    | in  | wr_en, index[2:0], wdata[31:0]                           | -
// Mark: two index divisions and one row read, then the cell write for an obstacle point.
// Traversable points first scan the window rows: a row in the grid is read and checked,
// a row outside it is skipped; then the target row is re-read before the write.
// Clear: one row word per cycle over all SIDE rows, then the result.
// Read: one row read, then the result. Reset: a clearing pass over all SIDE rows runs first.
// A result waits in the output register; in_tready is low from accept until it is taken.
module occupancy_grid_marker_core #(
  parameter int MAX_HALF_CELLS  = 63,
  parameter int MAX_WINDOW_HALF = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // command, point_x, point_y, terrain_class, read_row, read_col
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // cell_row, cell_col, cell_state, cell_written
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam int SIDE = 2 * MAX_HALF_CELLS + 1;
  localparam int RW   = $clog2(SIDE);
  localparam int WW   = $clog2(MAX_WINDOW_HALF + 1) + 1;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_DIVX = 4'd2, S_DIVY = 4'd3,
    S_RD0 = 4'd4, S_RD1 = 4'd5, S_SCAN = 4'd6, S_SWAIT = 4'd7, S_WRITE = 4'd8,
    S_OUT = 4'd9, S_READ = 4'd10, S_READ1 = 4'd11, S_REREAD = 4'd12;

  // grid memory: one row word per entry, SIDE cells of 2 bits
  logic [2*SIDE-1:0] mem [SIDE];
  logic [2*SIDE-1:0] rdata_r;
  logic              we;
  logic [RW-1:0]     waddr, raddr;
  logic [2*SIDE-1:0] wdata;

  logic [3:0]  state_r, state_nxt;
  logic [RW-1:0] clr_r, clr_nxt;
  logic [31:0] rx_r, ry_r;
  logic [15:0] cs_r;
  logic [5:0]  half_r;
  logic [3:0]  wx_r, wy_r;

  logic [1:0]  cmd_r, cls_r;
  logic [31:0] py_r;
  logic [6:0]  row_r, col_r, row_nxt, col_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic        res_wr_r, res_wr_nxt, found_r, found_nxt;
  logic signed [WW:0] di_r, di_nxt;
  logic        ov_r, ov_nxt;

  ogm_pkg::div_req_t dreq;
  ogm_pkg::div_rsp_t drsp;

  logic [7:0] half_eff, w_eff;
  logic [16:0] cs2;
  logic [15:0] cs_eff;
  logic signed [35:0] qv, qc;
  logic [6:0] idx;
  logic signed [9:0] srow;
  logic [RW-1:0] srow_i;
  logic [1:0] scell;
  logic in_acc;

  ogm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    half_eff = (32'(half_r) > MAX_HALF_CELLS) ? 8'(MAX_HALF_CELLS) : {2'b0, half_r};
    w_eff    = 8'({half_eff, 1'b0} + 9'd1);
    cs_eff   = (cs_r == 16'd0) ? 16'd1 : cs_r;
    cs2      = {cs_eff, 1'b0};
    // clamp quotient, add half
    qv = {drsp.quo[34], drsp.quo};
    if (qv < -$signed({28'd0, half_eff}))     qc = -$signed({28'd0, half_eff});
    else if (qv > $signed({28'd0, half_eff})) qc = $signed({28'd0, half_eff});
    else qc = qv;
    idx = 7'(qc + $signed({28'd0, half_eff}));
    srow = $signed({3'b0, row_r}) + 10'(di_r);
    srow_i = RW'(srow);
    scell = rdata_r[2*col_r +: 2];
  end

  // window OR across the row word, masked to columns in grid
  logic win_hit;
  always_comb begin
    int j;
    int lo, hi;
    lo = int'(col_r) - int'(wy_r > MAX_WINDOW_HALF ? 4'(MAX_WINDOW_HALF) : wy_r);
    hi = int'(col_r) + int'(wy_r > MAX_WINDOW_HALF ? 4'(MAX_WINDOW_HALF) : wy_r);
    win_hit = 1'b0;
    for (j = 0; j < SIDE; j++) begin
      if (j >= lo && j <= hi && j < int'(w_eff) && rdata_r[2*j +: 2] == ogm_pkg::ST_OCCUPIED)
        win_hit = 1'b1;
    end
  end

  logic signed [WW:0] wxs;
  assign wxs = $signed({2'b0, (wx_r > MAX_WINDOW_HALF ? 4'(MAX_WINDOW_HALF) : wx_r)});
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    row_nxt = row_r; col_nxt = col_r;
    res_st_nxt = res_st_r; res_wr_nxt = res_wr_r; found_nxt = found_r;
    di_nxt = di_r; ov_nxt = ov_r;
    we = 1'b0; waddr = clr_r; wdata = '0; raddr = row_r[RW-1:0];
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = cs2;
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        clr_nxt = clr_r + RW'(1);
        if (clr_r == RW'(SIDE - 1)) begin
          clr_nxt = '0;
          state_nxt = (cmd_r == ogm_pkg::CMD_CLEAR && ov_r) ? S_OUT : S_IDLE;
          ov_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          row_nxt = '0; col_nxt = '0; res_st_nxt = ogm_pkg::ST_UNKNOWN; res_wr_nxt = 1'b0;
          case (in_tdata[1:0])
            ogm_pkg::CMD_CLEAR: begin
              res_wr_nxt = 1'b1; ov_nxt = 1'b1; clr_nxt = '0; state_nxt = S_INIT;
            end
            ogm_pkg::CMD_MARK: begin
              dreq.start = 1'b1;
              dreq.num = 35'((({{3{in_tdata[33]}}, in_tdata[33:2]}
                          - {{3{rx_r[31]}}, rx_r}) << 1) + {19'd0, cs_eff});
              state_nxt = S_DIVX;
            end
            ogm_pkg::CMD_READ: begin
              row_nxt = in_tdata[74:68]; col_nxt = in_tdata[81:75];
              state_nxt = S_READ;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_DIVX: if (drsp.done) begin
        row_nxt = idx;
        dreq.start = 1'b1;
        dreq.num = 35'((({{3{py_r[31]}}, py_r} - {{3{ry_r[31]}}, ry_r}) << 1)
                       + {19'd0, cs_eff});
        state_nxt = S_DIVY;
      end
      S_DIVY: if (drsp.done) begin
        col_nxt = idx; state_nxt = S_RD0;
      end
      S_RD0: state_nxt = S_RD1;       // row word read in flight
      S_RD1: begin
        res_st_nxt = scell;
        if (cls_r <= 2'd1) begin
          res_st_nxt = ogm_pkg::ST_OCCUPIED; res_wr_nxt = 1'b1; state_nxt = S_WRITE;
        end else if (cls_r == ogm_pkg::CLS_TRAV && scell != ogm_pkg::ST_OCCUPIED) begin
          di_nxt = -wxs; found_nxt = 1'b0; state_nxt = S_SCAN;
        end else state_nxt = S_OUT;
      end
      S_SCAN: begin
        raddr = srow_i;
        if (srow >= 0 && srow < $signed({2'b0, w_eff})) state_nxt = S_SWAIT;
        else if (di_r >= wxs) begin
          res_st_nxt = found_r ? ogm_pkg::ST_NEAR : ogm_pkg::ST_FREE;
          res_wr_nxt = 1'b1;
          state_nxt = S_REREAD;
        end else di_nxt = di_r + (WW+1)'(1);
      end
      S_SWAIT: begin
        if (win_hit) found_nxt = 1'b1;
        if (di_r >= wxs) begin
          res_st_nxt = (found_r || win_hit) ? ogm_pkg::ST_NEAR : ogm_pkg::ST_FREE;
          res_wr_nxt = 1'b1;
          state_nxt = S_REREAD;
        end else begin
          di_nxt = di_r + (WW+1)'(1); state_nxt = S_SCAN;
        end
      end
      S_REREAD: state_nxt = S_WRITE;  // target row read in flight
      S_WRITE: begin
        if (res_wr_r) begin
          we = 1'b1; waddr = row_r[RW-1:0];
          wdata = rdata_r;
          wdata[2*col_r +: 2] = res_st_r;
        end
        state_nxt = S_OUT;
      end
      S_READ: state_nxt = S_READ1;
      S_READ1: begin
        if ({1'b0, row_r} < w_eff && {1'b0, col_r} < w_eff) res_st_nxt = scell;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt; col_r <= col_nxt;
    res_st_r <= res_st_nxt; res_wr_r <= res_wr_nxt; found_r <= found_nxt; di_r <= di_nxt;
    if (in_acc) begin
      cmd_r <= in_tdata[1:0]; py_r <= in_tdata[65:34]; cls_r <= in_tdata[67:66];
    end
    if (!rst_n) begin
      state_r <= S_INIT; clr_r <= '0; ov_r <= 1'b0;
      rx_r <= '0; ry_r <= '0; cs_r <= 16'd102; half_r <= 6'd50; wx_r <= 4'd3; wy_r <= 4'd3;
      out_tvalid <= 1'b0; out_tdata <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          ogm_pkg::REG_ROBOT_X: rx_r <= cfg_wdata;
          ogm_pkg::REG_ROBOT_Y: ry_r <= cfg_wdata;
          ogm_pkg::REG_CELL:    cs_r <= cfg_wdata[15:0];
          ogm_pkg::REG_HALF:    half_r <= cfg_wdata[5:0];
          ogm_pkg::REG_WIN_X:   wx_r <= cfg_wdata[3:0];
          ogm_pkg::REG_WIN_Y:   wy_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT) begin
        out_tvalid <= 1'b1;
        out_tdata  <= {7'd0, res_wr_r, res_st_r, col_r, row_r};
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/ogm_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle; floor semantics for signed numerator.
module ogm_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ogm_pkg::div_req_t req,
  output ogm_pkg::div_rsp_t      rsp
);
  logic [34:0] mag_r, mag_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] sh;
  logic [35:0] q_full;

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[16:0], mag_r[34]};
    if (req.start) begin
      neg_nxt  = req.num[34];
      mag_nxt  = req.num[34] ? (~req.num + 35'd1) : req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = 6'd35;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        mag_nxt = {mag_r[33:0], 1'b1};
      end else begin
        rem_nxt = sh;
        mag_nxt = {mag_r[33:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // negative with remainder: -(q+1)
  always_comb begin
    q_full = {1'b0, mag_r};
    if (neg_r) begin
      if (rem_r != '0) q_full = ~({1'b0, mag_r} + 36'd1) + 36'd1;
      else             q_full = ~{1'b0, mag_r} + 36'd1;
    end
    rsp.done = done_r;
    rsp.quo  = q_full[34:0];
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule
`default_nettype wire
